/* sv/bse_pkg.sv */
`default_nettype none
package bse_pkg;

	localparam int unsigned PRES_W = 16;
	localparam int unsigned LEVEL_W = 17;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [LEVEL_W-1:0] HALF_Q16 = 17'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REFLEX_ACTIVE = 3'd0,
		CFG_PRESSURE_SETPOINT = 3'd1,
		CFG_SIGMOID_SLOPE = 3'd2,
		CFG_DRIVE_RATE = 3'd3,
		CFG_RECOVERY_RATE = 3'd4,
		CFG_STEP_SECONDS = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULX,
		ST_INDEX,
		ST_LOOKUP,
		ST_INTERP,
		ST_DEV,
		ST_RATE,
		ST_PROD,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;
		logic mulx;
		logic index;
		logic lookup;
		logic interp;
		logic dev;
		logic rate;
		logic prod;
		logic update;
	} cmd_t;

endpackage
`default_nettype wire

/* sv/bse_if.sv */
`default_nettype none
interface bse_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] monitored_pressure;

	modport source(output valid, output monitored_pressure, input ready);
	modport sink(input valid, input monitored_pressure, output ready);
endinterface

interface bse_out_if;
	logic valid;
	logic ready;
	logic [16:0] afferent_level;
	logic [16:0] efferent_level;

	modport source(output valid, output afferent_level, output efferent_level, input ready);
	modport sink(input valid, input afferent_level, input efferent_level, output ready);
endinterface
`default_nettype wire

/* sv/bse_ctrl.sv */
`default_nettype none
module bse_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	output bse_pkg::cmd_t cmd
);
	import bse_pkg::*;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	logic out_free;

	// the result register may be refilled in the same cycle it is taken
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MULX;
			end
			ST_MULX: state_d = ST_INDEX;
			ST_INDEX: state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_INTERP;
			ST_INTERP: state_d = ST_DEV;
			ST_DEV: state_d = ST_RATE;
			ST_RATE: state_d = ST_PROD;
			ST_PROD: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MULX: cmd.mulx = 1'b1;
			ST_INDEX: cmd.index = 1'b1;
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_INTERP: cmd.interp = 1'b1;
			ST_DEV: cmd.dev = 1'b1;
			ST_RATE: cmd.rate = 1'b1;
			ST_PROD: cmd.prod = 1'b1;
			ST_UPDATE: cmd.update = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* sv/bse_datapath.sv */
`default_nettype none
module bse_datapath #(
	parameter int unsigned SIGMOID_ENTRIES = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [bse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bse_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire bse_pkg::cmd_t cmd,
	input  wire logic signed [bse_pkg::PRES_W-1:0] monitored_pressure,
	output logic [bse_pkg::LEVEL_W-1:0] afferent_level,
	output logic [bse_pkg::LEVEL_W-1:0] efferent_level
);
	import bse_pkg::*;

	localparam int unsigned IDX_W = $clog2(SIGMOID_ENTRIES);
	localparam int unsigned POS_W = 18 + IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIGMOID_ENTRIES - 1);
	localparam logic [POS_W-1:0] SPAN = POS_W'(SIGMOID_ENTRIES - 1);
	localparam logic signed [33:0] X_LIM = 34'sd131072;

	// shift-subtract quotient, only evaluated while building the constant table
	function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		int bit_n;
		quo = '0;
		rem = '0;
		for (bit_n = 63; bit_n >= 0; bit_n--) begin
			rem = {rem[62:0], num[bit_n]};
			if (rem >= den) begin
				rem = rem - den;
				quo[bit_n] = 1'b1;
			end
		end
		return quo;
	endfunction

	// logistic(-8 + 16*i/(N-1)) in Q1.16; exp via Q.31 Taylor series of
	// exp(-y/16) squared four times
	function automatic logic [16:0] sig_entry(input int unsigned i);
		logic [63:0] eight, q, y, z, term, s, d, a;
		logic signed [63:0] sum;
		logic neg;
		int k;
		int n;
		eight = 64'd8 << 31;
		q = cdiv((64'd16 * 64'(i)) << 31, 64'(SIGMOID_ENTRIES - 1));
		neg = q < eight;
		y = neg ? eight - q : q - eight;
		z = y >> 4;
		term = 64'd1 << 31;
		sum = 64'sd1 <<< 31;
		for (k = 1; k <= 20; k++) begin
			term = cdiv((term * z) >> 31, 64'(k));
			if (k[0]) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		if (sum < 0) sum = '0;
		s = $unsigned(sum);
		for (n = 0; n < 4; n++) s = (s * s + (64'd1 << 30)) >> 31;
		d = (64'd1 << 31) + s;
		a = cdiv((64'd1 << 47) + (d >> 1), d);
		if (a > 64'd65536) a = 64'd65536;
		return neg ? 17'(64'd65536 - a) : 17'(a);
	endfunction

	logic [16:0] sig_tab [SIGMOID_ENTRIES];
	for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_tab
		localparam logic [16:0] ENTRY = sig_entry(g);
		assign sig_tab[g] = ENTRY;
	end

	// configuration
	logic active_q;
	logic signed [15:0] pset_q;
	logic [15:0] slope_q, kdrive_q, krecov_q;
	logic [23:0] dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pset_q <= 16'sd5760;
			slope_q <= 16'd256;
			kdrive_q <= 16'd256;
			krecov_q <= 16'd256;
			dt_q <= 24'd16777;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REFLEX_ACTIVE: active_q <= cfg_wdata[0];
				CFG_PRESSURE_SETPOINT: pset_q <= $signed(cfg_wdata[15:0]);
				CFG_SIGMOID_SLOPE: slope_q <= cfg_wdata[15:0];
				CFG_DRIVE_RATE: kdrive_q <= cfg_wdata[15:0];
				CFG_RECOVERY_RATE: krecov_q <= cfg_wdata[15:0];
				CFG_STEP_SECONDS: dt_q <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// working registers
	logic signed [15:0] p_q;
	logic signed [33:0] x_q;
	logic lo_q, hi_q;
	logic [IDX_W-1:0] idx_q;
	logic [17:0] frac_q;
	logic [16:0] t0_q, t1_q;
	logic [16:0] a_q;
	logic [15:0] m_q;
	logic down_q;
	logic [31:0] km_q;
	logic [55:0] prod_q;
	logic [16:0] b_q;
	logic [16:0] out_a_q, out_b_q;

	// x = S * (P - Pset), exact
	logic signed [16:0] diff_d, slope_s;
	logic signed [33:0] x_d;
	assign diff_d = 17'(p_q) - 17'(pset_q);
	assign slope_s = $signed({1'b0, slope_q});
	assign x_d = slope_s * diff_d;

	// table position; u = x + 8.0 only meaningful when not saturated
	logic [17:0] u_d;
	logic [POS_W-1:0] pos_d;
	assign u_d = {~x_q[17], x_q[16:0]};
	assign pos_d = POS_W'(u_d) * SPAN;

	logic [IDX_W-1:0] idx_nx;
	logic [16:0] sel_d;
	assign idx_nx = idx_q + 1'b1;
	assign sel_d = lo_q ? sig_tab[0] : sig_tab[LAST_IDX];

	// A = t0 + (t1 - t0) * f / 2^18, rounded
	logic signed [17:0] dt01_d;
	logic signed [18:0] frac_s;
	logic signed [37:0] dprod_d, v_d;
	assign dt01_d = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
	assign frac_s = $signed({1'b0, frac_q});
	assign dprod_d = dt01_d * frac_s;
	assign v_d = $signed({3'b000, t0_q, 18'd0}) + dprod_d + 38'sd131072;

	// deviation and factor
	logic [15:0] dev_d;
	logic [16:0] fac_d;
	logic down_d;
	logic [32:0] df_d;
	always_comb begin
		if (a_q >= HALF_Q16) begin
			dev_d = 16'(a_q - HALF_Q16);
			fac_d = b_q;
			down_d = 1'b1;
		end else begin
			dev_d = 16'(HALF_Q16 - a_q);
			fac_d = ONE_Q16 - b_q;
			down_d = 1'b0;
		end
	end
	assign df_d = 33'(dev_d) * 33'(fac_d) + 33'd32768;

	logic [15:0] k_d;
	assign k_d = active_q ? kdrive_q : krecov_q;

	// B update with rounding and clamp
	logic [56:0] rnd_d;
	logic [24:0] mag_d;
	logic signed [26:0] nb_d;
	logic [16:0] bclamp_d;
	assign rnd_d = 57'(prod_q) + 57'h80000000;
	assign mag_d = rnd_d[56:32];
	assign nb_d = down_q ? 27'(b_q) - 27'(mag_d) : 27'(b_q) + 27'(mag_d);
	always_comb begin
		if (nb_d < 0) bclamp_d = '0;
		else if (nb_d > 27'sd65536) bclamp_d = ONE_Q16;
		else bclamp_d = nb_d[16:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) p_q <= monitored_pressure;
		if (cmd.mulx) x_q <= x_d;
		if (cmd.index) begin
			lo_q <= x_q <= -X_LIM;
			hi_q <= x_q >= X_LIM;
			idx_q <= pos_d[18 +: IDX_W];
			frac_q <= pos_d[17:0];
		end
		if (cmd.lookup) begin
			if (lo_q || hi_q) begin
				t0_q <= sel_d;
				t1_q <= sel_d;
			end else begin
				t0_q <= sig_tab[idx_q];
				t1_q <= sig_tab[idx_nx];
			end
		end
		if (cmd.interp) a_q <= v_d[34:18];
		if (cmd.dev) begin
			if (active_q) begin
				m_q <= df_d[31:16];
				down_q <= down_d;
			end else if (b_q >= HALF_Q16) begin
				m_q <= 16'(b_q - HALF_Q16);
				down_q <= 1'b1;
			end else begin
				m_q <= 16'(HALF_Q16 - b_q);
				down_q <= 1'b0;
			end
		end
		if (cmd.rate) km_q <= 32'(k_d) * 32'(m_q);
		if (cmd.prod) prod_q <= 56'(km_q) * 56'(dt_q);
		if (cmd.update) begin
			out_a_q <= a_q;
			out_b_q <= bclamp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) b_q <= HALF_Q16;
		else if (cmd.update) b_q <= bclamp_d;
	end

	assign afferent_level = out_a_q;
	assign efferent_level = out_b_q;

endmodule
`default_nettype wire

/* sv/baroreflex_sigmoid_euler_step.sv */
`default_nettype none
// channel   dir  fields                              
// sample    in   monitored_pressure (s16, Q10.6)      
// result    out  afferent_level, efferent_level (Q1.16)
// cfg       in   cfg_we / cfg_index / cfg_wdata[23:0]
//
// One word at a time; a new sample waits until the last is through:
// accept, then eight sequencer steps (slope multiply, table position,
// table read, interpolation, deviation product, rate product, dt product, update).
// Reset restores the register defaults and B = 0.5; the sigmoid table is constant.
// A stalled result holds the update step; no new sample is taken meanwhile.
module baroreflex_sigmoid_euler_step #(
	parameter int unsigned SIGMOID_ENTRIES = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [bse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bse_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bse_in_if.sink sample,
	bse_out_if.source result
);
	import bse_pkg::*;

	cmd_t cmd;
	logic in_ready, out_valid;

	bse_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sample.valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(result.ready),
		.cmd(cmd)
	);

	bse_datapath #(
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.monitored_pressure(sample.monitored_pressure),
		.afferent_level(result.afferent_level),
		.efferent_level(result.efferent_level)
	);

	assign sample.ready = in_ready;
	assign result.valid = out_valid;

endmodule
`default_nettype wire

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bse_pkg::*;

	localparam int unsigned SIGMOID_ENTRIES = 256;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS = 107;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam longint unsigned Q31_ONE = 64'd1 << 31;
	// sigmoid argument saturates at +/-8.0 in Q.14
	localparam longint X_LIMIT = 64'sd131072;

	typedef struct packed {
		logic [LEVEL_W-1:0] afferent;
		logic [LEVEL_W-1:0] efferent;
	} level_pair_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bse_in_if in_if();
	bse_out_if out_if();

	baroreflex_sigmoid_euler_step #(
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample(in_if),
		.result(out_if)
	);

	// predictor copy of the registers and of B
	logic reg_active;
	logic signed [15:0] reg_setpoint;
	logic [15:0] reg_slope;
	logic [15:0] reg_drive;
	logic [15:0] reg_recov;
	logic [23:0] reg_dt;
	logic [LEVEL_W-1:0] b_level;
	longint unsigned logistic_rom [SIGMOID_ENTRIES];

	level_pair_t pending_levels[$];
	int level_errors = 0;
	int cycle_count = 0;
	int stall_left = 0;
	logic steady = 1'b0;

	always #6 clk = ~clk;

	function automatic longint unsigned exp_neg_q31(longint unsigned y);
		longint unsigned z;
		longint unsigned term;
		longint unsigned s;
		longint acc;
		z = y >> 4;
		term = Q31_ONE;
		acc = longint'(Q31_ONE);
		for (int k = 1; k <= 20; k++) begin
			term = ((term * z) >> 31) / longint'(k);
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		s = longint'(acc);
		// exp(-y) = exp(-y/16)^16
		for (int n = 0; n < 4; n++)
			s = (s * s + (64'd1 << 30)) >> 31;
		return s;
	endfunction

	function automatic void build_logistic_rom();
		longint unsigned q;
		longint unsigned y;
		longint unsigned d;
		longint unsigned a;
		logic neg;
		for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
			q = ((64'd16 * longint'(i)) << 31) / longint'(SIGMOID_ENTRIES - 1);
			neg = q < (64'd8 << 31);
			y = neg ? (64'd8 << 31) - q : q - (64'd8 << 31);
			d = Q31_ONE + exp_neg_q31(y);
			a = ((64'd1 << 47) + (d >> 1)) / d;
			if (a > 64'd65536)
				a = 64'd65536;
			logistic_rom[i] = neg ? 64'd65536 - a : a;
		end
	endfunction

	function automatic longint unsigned afferent_of(longint x);
		longint unsigned u;
		longint unsigned pos;
		longint unsigned idx;
		longint unsigned frac;
		if (x <= -X_LIMIT)
			return logistic_rom[0];
		if (x >= X_LIMIT)
			return logistic_rom[SIGMOID_ENTRIES-1];
		u = longint'(x + X_LIMIT);
		pos = u * longint'(SIGMOID_ENTRIES - 1);
		idx = pos >> 18;
		frac = pos & 64'h3FFFF;
		if (idx >= longint'(SIGMOID_ENTRIES - 1))
			return logistic_rom[SIGMOID_ENTRIES-1];
		return (logistic_rom[idx] * ((64'd1 << 18) - frac)
			+ logistic_rom[idx+1] * frac + (64'd1 << 17)) >> 18;
	endfunction

	function automatic level_pair_t predict_levels(logic signed [15:0] p);
		longint x;
		longint nb;
		longint unsigned a;
		longint unsigned b;
		longint unsigned dev;
		longint unsigned fac;
		longint unsigned mag;
		longint unsigned prod;
		logic down;
		level_pair_t r;
		x = longint'(reg_slope) * (longint'(p) - longint'(reg_setpoint));
		a = afferent_of(x);
		b = longint'(b_level);
		if (reg_active) begin
			if (a >= longint'(HALF_Q16)) begin
				dev = a - longint'(HALF_Q16);
				fac = b;
				down = 1'b1;
			end else begin
				dev = longint'(HALF_Q16) - a;
				fac = longint'(ONE_Q16) - b;
				down = 1'b0;
			end
			mag = (dev * fac + (64'd1 << 15)) >> 16;
			prod = longint'(reg_drive) * mag * longint'(reg_dt);
		end else begin
			if (b >= longint'(HALF_Q16)) begin
				dev = b - longint'(HALF_Q16);
				down = 1'b1;
			end else begin
				dev = longint'(HALF_Q16) - b;
				down = 1'b0;
			end
			prod = longint'(reg_recov) * dev * longint'(reg_dt);
		end
		mag = (prod + (64'd1 << 31)) >> 32;
		nb = down ? longint'(b) - longint'(mag) : longint'(b) + longint'(mag);
		if (nb < 0)
			nb = 0;
		if (nb > 65536)
			nb = 65536;
		b_level = nb[LEVEL_W-1:0];
		r.afferent = a[LEVEL_W-1:0];
		r.efferent = b_level;
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_REFLEX_ACTIVE: reg_active = val[0];
			CFG_PRESSURE_SETPOINT: reg_setpoint = val[15:0];
			CFG_SIGMOID_SLOPE: reg_slope = val[15:0];
			CFG_DRIVE_RATE: reg_drive = val[15:0];
			CFG_RECOVERY_RATE: reg_recov = val[15:0];
			CFG_STEP_SECONDS: reg_dt = val;
			default: ;
		endcase
	endfunction

	function automatic void flag_error(string what, longint unsigned want, longint unsigned got);
		level_errors++;
		if (level_errors <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endfunction

	// random upper bits above the register width; the block must drop them
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int width);
		logic [CFG_DATA_W-1:0] mask;
		mask = (24'd1 << width) - 24'd1;
		return (CFG_DATA_W'($urandom) & ~mask) | (v & mask);
	endfunction

	task automatic send_pressure(input logic signed [15:0] p);
		if (!steady && $urandom_range(0, 99) < 6) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.monitored_pressure <= p;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		pending_levels.push_back(predict_levels(p));
	endtask

	task automatic drain_results(input int tail);
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		apply_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reset_defaults();
		send_pressure(-16'sd32768);
		send_pressure(16'sd32767);
		send_pressure(16'sd5760);
		send_pressure(16'sd0);
		drain_results(3);
	endtask

	task automatic check_sigmoid_edges();
		write_reg(CFG_REFLEX_ACTIVE, 24'd1);
		// slope 1.0: 512 counts of pressure is exactly 8.0 of argument
		send_pressure(16'sd5760 - 16'sd512);
		send_pressure(16'sd5760 - 16'sd511);
		send_pressure(16'sd5760);
		send_pressure(16'sd5760 + 16'sd3);
		send_pressure(16'sd5760 + 16'sd511);
		send_pressure(16'sd5760 + 16'sd512);
		drain_results(3);
	endtask

	task automatic check_clamping();
		write_reg(CFG_DRIVE_RATE, 24'h00FFFF);
		write_reg(CFG_STEP_SECONDS, 24'hFFFFFF);
		repeat (3) send_pressure(16'sd32767);
		repeat (3) send_pressure(-16'sd32768);
		drain_results(3);
		// B sits at 1.0 now; fast recovery overshoots below zero
		write_reg(CFG_REFLEX_ACTIVE, 24'd0);
		write_reg(CFG_RECOVERY_RATE, 24'h00FFFF);
		send_pressure(16'sd100);
		send_pressure(-16'sd100);
		drain_results(3);
	endtask

	task automatic check_zero_step();
		write_reg(CFG_STEP_SECONDS, 24'd0);
		send_pressure(16'sd4000);
		drain_results(3);
		write_reg(CFG_REFLEX_ACTIVE, 24'd1);
		send_pressure(-16'sd20000);
		send_pressure(16'sd20000);
		drain_results(3);
	endtask

	task automatic check_register_decode();
		write_reg(CFG_STEP_SECONDS, 24'd16777);
		write_reg(REG_SPARE_LO, 24'hFFFFFF);
		write_reg(REG_SPARE_HI, 24'hFFFFFF);
		write_reg(CFG_REFLEX_ACTIVE, 24'hFFFFFE);
		write_reg(CFG_PRESSURE_SETPOINT, 24'hAB1680);
		send_pressure(16'sd6000);
		send_pressure(-16'sd1);
		drain_results(3);
	endtask

	task automatic set_random_config(input int ph);
		logic [CFG_DATA_W-1:0] v;
		if (ph == 0) begin
			write_reg(CFG_REFLEX_ACTIVE, with_junk(24'd1, 1));
			write_reg(CFG_PRESSURE_SETPOINT, with_junk(24'h007FFF, 16));
			write_reg(CFG_SIGMOID_SLOPE, with_junk(24'h00FFFF, 16));
			write_reg(CFG_DRIVE_RATE, with_junk(24'h00FFFF, 16));
			write_reg(CFG_RECOVERY_RATE, with_junk(24'h00FFFF, 16));
			write_reg(CFG_STEP_SECONDS, 24'hFFFFFF);
		end else if (ph == 1) begin
			write_reg(CFG_REFLEX_ACTIVE, with_junk(24'd0, 1));
			write_reg(CFG_PRESSURE_SETPOINT, with_junk(24'h008000, 16));
			write_reg(CFG_SIGMOID_SLOPE, with_junk(24'd0, 16));
			write_reg(CFG_DRIVE_RATE, with_junk(24'd0, 16));
			write_reg(CFG_RECOVERY_RATE, with_junk(24'd0, 16));
			write_reg(CFG_STEP_SECONDS, 24'd1);
		end else begin
			write_reg(CFG_REFLEX_ACTIVE, with_junk(24'($urandom_range(0, 1)), 1));
			v = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(4000, 8000))
				: 24'($urandom);
			write_reg(CFG_PRESSURE_SETPOINT, with_junk(v, 16));
			v = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(16, 2048))
				: 24'($urandom);
			write_reg(CFG_SIGMOID_SLOPE, with_junk(v, 16));
			v = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 4096))
				: 24'($urandom);
			write_reg(CFG_DRIVE_RATE, with_junk(v, 16));
			v = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 4096))
				: 24'($urandom);
			write_reg(CFG_RECOVERY_RATE, with_junk(v, 16));
			v = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(1, 262144))
				: 24'($urandom_range(1, 24'hFFFFFF));
			write_reg(CFG_STEP_SECONDS, v);
		end
	endtask

	task automatic run_random_phases();
		int span;
		int pv;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results(3);
			set_random_config(ph);
			steady = (ph == 4);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// mostly inside the unsaturated band around the setpoint
				if (reg_slope != 16'd0 && $urandom_range(0, 99) < 70) begin
					span = 131072 / int'(reg_slope) + 4;
					if (span > 32767)
						span = 32767;
					pv = int'(reg_setpoint) + int'($urandom_range(0, 2 * span)) - span;
					if (pv > 32767)
						pv = 32767;
					if (pv < -32768)
						pv = -32768;
					send_pressure(16'(pv));
				end else begin
					send_pressure(16'($urandom));
				end
			end
		end
		steady = 1'b0;
	endtask

	// result sink with random stalls of varying length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_if.ready <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < 1) begin
			stall_left <= $urandom_range(0, 10);
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		level_pair_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_levels.size() == 0) begin
				flag_error("word with nothing pending", 0, out_if.afferent_level);
			end else begin
				want = pending_levels.pop_front();
				if (out_if.afferent_level !== want.afferent)
					flag_error("afferent_level", want.afferent, out_if.afferent_level);
				if (out_if.efferent_level !== want.efferent)
					flag_error("efferent_level", want.efferent, out_if.efferent_level);
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_if.valid = 1'b0;
		in_if.monitored_pressure = '0;
		out_if.ready = 1'b0;
		reg_active = 1'b0;
		reg_setpoint = 16'sd5760;
		reg_slope = 16'd256;
		reg_drive = 16'd256;
		reg_recov = 16'd256;
		reg_dt = 24'd16777;
		b_level = HALF_Q16;
		build_logistic_rom();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_defaults();
		check_sigmoid_edges();
		check_clamping();
		check_zero_step();
		check_register_decode();
		run_random_phases();

		drain_results(20);
		if (level_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
